### rtl/core/hsct_pkg.sv
// ----------------------------------------------------------------------------
// hsct_pkg
// Shared widths, codes and types of the hashed saturating counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package hsct_pkg;

  localparam int HASH_W  = 64;
  localparam int LEN_W   = 17;
  localparam int COUNT_W = 16;
  localparam int STEP_W  = $clog2(HASH_W);

  localparam int DEF_TABLE_DEPTH   = 65536;
  localparam int DEF_COUNTER_WIDTH = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = 17'h10000;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/core/hsct_ram.sv
// ----------------------------------------------------------------------------
// hsct_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hsct_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/hsct_div.sv
// ----------------------------------------------------------------------------
// hsct_div
// Bit-serial restoring remainder unit: 64-bit dividend by a 17-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module hsct_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [hsct_pkg::HASH_W-1:0]    dividend,
  input  logic [hsct_pkg::LEN_W-1:0]     divisor,
  output hsct_pkg::div_stat_t            stat,
  output logic [hsct_pkg::LEN_W-1:0]     rem
);

  localparam int LW = hsct_pkg::LEN_W;
  localparam int HW = hsct_pkg::HASH_W;
  localparam int SW = hsct_pkg::STEP_W;
  localparam logic [SW-1:0] LAST_STEP = SW'(HW - 1);

  logic [HW-1:0] dvd_r, dvd_nxt;
  logic [LW-1:0] dsr_r, dsr_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [LW:0]   shifted;
  logic [LW:0]   diff;

  assign shifted = {rem_r, dvd_r[HW-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract when the shifted partial remainder reaches the divisor
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = diff[LW-1:0];
      end else begin
        rem_nxt = shifted[LW-1:0];
      end
      dvd_nxt  = {dvd_r[HW-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

`default_nettype wire

### rtl/core/hashed_saturating_counter_table_unit.sv
// ----------------------------------------------------------------------------
// hashed_saturating_counter_table_unit
// Table of saturating counters addressed by a hash modulo the table length.
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_ready  in_kind, in_hash
//  out_*        output     out_valid/out_ready out_count
//  cfg_*        input      cfg_we             cfg_wdata (table length)
//
//  A request passes from its accept in S_IDLE through S_DIV, where the
//  bit-serial remainder unit works through the 64 hash bits and raises its
//  done flag, then S_READ (counter RAM read) and S_UPDATE, which writes back
//  and loads out. After reset a clearing pass zeroes all TABLE_DEPTH entries
//  (65536 by default) while in_ready stays low; cfg writes are taken at any
//  time. A stalled result holds in the output register; the next request is
//  taken meanwhile and waits in its update state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_saturating_counter_table_unit #(
  parameter int TABLE_DEPTH   = hsct_pkg::DEF_TABLE_DEPTH,
  parameter int COUNTER_WIDTH = hsct_pkg::DEF_COUNTER_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [hsct_pkg::HASH_W-1:0]  in_hash,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hsct_pkg::COUNT_W-1:0] out_count,
  input  logic                         cfg_we,
  input  logic [hsct_pkg::LEN_W-1:0]   cfg_wdata
);

  localparam int LW     = hsct_pkg::LEN_W;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_MAX = (1 << LW) - 1;
  localparam int LEN_CAP = (TABLE_DEPTH > LEN_MAX) ? LEN_MAX : TABLE_DEPTH;
  localparam logic [LW-1:0] CAP_L = LW'(LEN_CAP);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_DIV    = 5'b00100,
    S_READ   = 5'b01000,
    S_UPDATE = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ADDR_W-1:0]          clr_addr_r, clr_addr_nxt;
  logic [LW-1:0]              len_r;
  logic                       kind_r, kind_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [hsct_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic [LW-1:0]              eff_len;
  logic                       div_start;
  hsct_pkg::div_stat_t        div_stat;
  logic [LW-1:0]              div_rem;

  logic                       ram_we, ram_re;
  logic [ADDR_W-1:0]          ram_addr;
  logic [COUNTER_WIDTH-1:0]   ram_wdata, ram_rdata;
  logic [COUNTER_WIDTH-1:0]   new_val;
  logic                       accept;
  logic                       out_free;

  // clamp length to one .. table depth
  always_comb begin
    if (len_r == '0) begin
      eff_len = LW'(1);
    end else if (len_r > CAP_L) begin
      eff_len = CAP_L;
    end else begin
      eff_len = len_r;
    end
  end

  assign accept    = in_valid && in_ready;
  assign div_start = accept;
  assign out_free  = !out_valid_r || out_ready;

  hsct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_hash),
    .divisor  (eff_len),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  always_comb begin
    if ((kind_r == hsct_pkg::KIND_COUNT) && (ram_rdata != CNT_MAX)) begin
      new_val = ram_rdata + 1'b1;
    end else begin
      new_val = ram_rdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = ADDR_W'(div_rem);
    ram_wdata     = new_val;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the output register is free
        if (out_free) begin
          ram_we        = (kind_r == hsct_pkg::KIND_COUNT);
          out_valid_nxt = 1'b1;
          out_count_nxt = hsct_pkg::COUNT_W'(new_val);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  hsct_ram #(
    .WIDTH (COUNTER_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      len_r       <= hsct_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
    kind_r      <= kind_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DIV) && div_stat.busy)
    else $error("accepted request did not start the remainder unit");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("remainder unit finished outside the divide state");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPDATE))
    else $error("result raised without an update cycle");

  a_write_only_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r != S_CLEAR)) |-> (kind_r == hsct_pkg::KIND_COUNT))
    else $error("counter written by a query request");

endmodule

`default_nettype wire

### tb/sv/hashed_saturating_counter_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_saturating_counter_table_checker
// Watches the request, result and table length ports of the counter table,
// keeps its own copy of the counters and checks every returned count in order.
// ----------------------------------------------------------------------------

module hashed_saturating_counter_table_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_kind,
  input  logic [hsct_pkg::HASH_W-1:0]  in_hash,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [hsct_pkg::COUNT_W-1:0] out_count,
  input  logic                         cfg_we,
  input  logic [hsct_pkg::LEN_W-1:0]   cfg_wdata,
  output int                           fail_count,
  output int                           pending
);

  localparam int HASH_W  = hsct_pkg::HASH_W;
  localparam int LEN_W   = hsct_pkg::LEN_W;
  localparam int COUNT_W = hsct_pkg::COUNT_W;
  localparam int CNT_W   = hsct_pkg::DEF_COUNTER_WIDTH;
  localparam int DEPTH   = hsct_pkg::DEF_TABLE_DEPTH;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] COUNTER_FULL = '1;

  logic [CNT_W-1:0]             slot_count [DEPTH];
  logic [LEN_W-1:0]             table_len;
  logic [COUNT_W-1:0]           expected_counts [$];
  logic [COUNT_W-1:0]           want;
  int                           mismatches = 0;

  // Reduce the hash over the clamped table length.
  function automatic logic [IDX_W-1:0] slot_of(input logic [HASH_W-1:0] hash);
    logic [HASH_W-1:0] len;
    logic [HASH_W-1:0] slot;
    len = {{(HASH_W-LEN_W){1'b0}}, table_len};
    if (len == '0) len = HASH_W'(1);
    if (len > HASH_W'(DEPTH)) len = HASH_W'(DEPTH);
    slot = hash % len;
    return slot[IDX_W-1:0];
  endfunction

  // Apply one request to the counter copy and return the count it reports.
  function automatic logic [COUNT_W-1:0] apply_request(input logic kind,
                                                       input logic [HASH_W-1:0] hash);
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] value;
    slot  = slot_of(hash);
    value = slot_count[slot];
    if (kind == hsct_pkg::KIND_COUNT) begin
      if (value != COUNTER_FULL) value = value + 1'b1;
      slot_count[slot] = value;
    end
    return COUNT_W'(value);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) slot_count[i] = '0;
      table_len = hsct_pkg::LEN_RESET;
      expected_counts.delete();
    end else begin
      // a request taken with a write still sees the old length
      if (in_valid && in_ready) expected_counts.push_back(apply_request(in_kind, in_hash));
      if (cfg_we) table_len = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: count %0d", out_count);
          mismatches++;
        end else begin
          want = expected_counts.pop_front();
          if (out_count !== want) begin
            if (mismatches < 10) begin
              $display("count mismatch: expected %0d, actual %0d", want, out_count);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_counts.size();
  end

endmodule

### tb/sv/hashed_saturating_counter_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_saturating_counter_table_unit_tb
// Drives count and query requests over a range of table lengths, with random
// gaps on the request side and random stalls on the result side, and reports
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------

module hashed_saturating_counter_table_unit_tb;

  localparam int HASH_W      = hsct_pkg::HASH_W;
  localparam int LEN_W       = hsct_pkg::LEN_W;
  localparam int COUNT_W     = hsct_pkg::COUNT_W;
  localparam int QUIET_LIMIT = 300000;
  localparam int POOL_SIZE   = 6;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_kind;
  logic [HASH_W-1:0]   in_hash;
  logic                out_valid;
  logic                out_ready;
  logic [COUNT_W-1:0]  out_count;
  logic                cfg_we;
  logic [LEN_W-1:0]    cfg_wdata;

  int                  fail_count;
  int                  pending;
  int                  quiet_cycles = 0;
  int                  ready_hold = 0;
  bit                  stall_on = 1'b1;
  int                  calm_left = 0;
  logic [HASH_W-1:0]   hash_pool [POOL_SIZE];

  hashed_saturating_counter_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_hash   (in_hash),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_count (out_count),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hashed_saturating_counter_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_hash    (in_hash),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_count  (out_count),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 5);
    return $urandom_range(20, 160);
  endfunction

  // Result side: stall in bursts while stall mode is on.
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_on <= !stall_on;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      ready_hold <= pick_gap();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_req(input logic kind, input logic [HASH_W-1:0] hash);
    int gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_hash  <= hash;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every request has returned its count.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input int n);
    int                r;
    int                p;
    logic              k;
    logic [HASH_W-1:0] h;
    set_length(len);
    hash_pool[$urandom_range(0, POOL_SIZE-1)] = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, POOL_SIZE-1);
      if (r < 55) begin
        k = hsct_pkg::KIND_COUNT;
        h = hash_pool[p];
      end else if (r < 75) begin
        k = hsct_pkg::KIND_QUERY;
        h = hash_pool[p];
      end else if (r < 88) begin
        k = 1'($urandom_range(0, 1));
        h = {$urandom, $urandom};
      end else begin
        // another hash on a pool hash's slot, unless len > depth or it wraps
        k = 1'($urandom_range(0, 1));
        h = hash_pool[p] + 64'($urandom_range(1, 4096)) * 64'(len);
      end
      send_req(k, h);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_kind   = hsct_pkg::KIND_COUNT;
    in_hash   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < POOL_SIZE; i++) hash_pool[i] = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // full table after reset: low and high slots, wrap of the hash
    send_req(hsct_pkg::KIND_COUNT, 64'h0);
    send_req(hsct_pkg::KIND_COUNT, 64'h0);
    send_req(hsct_pkg::KIND_QUERY, 64'h0);
    send_req(hsct_pkg::KIND_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(hsct_pkg::KIND_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(hsct_pkg::KIND_COUNT, 64'h0000_0000_0001_0000);
    send_req(hsct_pkg::KIND_QUERY, 64'h0000_0000_0000_FFFF);
    send_req(hsct_pkg::KIND_COUNT, 64'h8000_0000_0000_0000);
    send_req(hsct_pkg::KIND_QUERY, 64'hFFFF_FFFF_FFFF_0000);

    // zero length acts as one: everything on slot 0
    set_length(17'd0);
    send_req(hsct_pkg::KIND_COUNT, {$urandom, $urandom});
    send_req(hsct_pkg::KIND_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(hsct_pkg::KIND_COUNT, 64'h5555_5555_5555_5555);

    set_length(17'd1);
    send_req(hsct_pkg::KIND_COUNT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(hsct_pkg::KIND_QUERY, 64'h1);

    // lengths above the table depth clamp to the depth
    set_length(17'h1FFFF);
    send_req(hsct_pkg::KIND_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(hsct_pkg::KIND_QUERY, 64'h0000_0000_0000_FFFF);

    set_length(17'h10001);
    send_req(hsct_pkg::KIND_COUNT, 64'h0000_0000_0001_0000);
    send_req(hsct_pkg::KIND_QUERY, 64'h0);

    set_length(17'd3);
    send_req(hsct_pkg::KIND_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(hsct_pkg::KIND_QUERY, 64'h3);

    run_phase(17'h10000, 55);
    run_phase(17'd1, 45);
    run_phase(17'd2, 45);
    run_phase(17'd0, 45);
    run_phase(17'd7, 50);
    run_phase(LEN_W'($urandom_range(8, 65535)), 55);
    run_phase(17'hFFFF, 50);
    run_phase(17'h1FFFF, 50);
    run_phase(LEN_W'($urandom_range(65537, 131071)), 45);
    run_phase(17'd13, 45);
    run_phase(LEN_W'($urandom_range(0, 131071)), 45);

    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
